// ----- hdl/lsdot_pkg.sv -----
// shared constants and types for the sprite draw order table
package lsdot_pkg;
    localparam int MAX_SPRITES  = 16;
    localparam int LAYER_BITS   = 16;
    localparam int TEXTURE_BITS = 16;
    localparam int SEQ_BITS     = 32;

    localparam logic [3:0] CMD_INIT     = 4'd0;
    localparam logic [3:0] CMD_SHUTDOWN = 4'd1;
    localparam logic [3:0] CMD_CLEAR    = 4'd2;
    localparam logic [3:0] CMD_CREATE   = 4'd3;
    localparam logic [3:0] CMD_REMOVE   = 4'd4;
    localparam logic [3:0] CMD_LAYER    = 4'd5;
    localparam logic [3:0] CMD_VISIBLE  = 4'd6;
    localparam logic [3:0] CMD_TEXTURE  = 4'd7;
    localparam logic [3:0] CMD_QUERY    = 4'd8;
    localparam logic [3:0] CMD_DRAW     = 4'd9;

    typedef struct packed {
        logic [3:0]  command;
        logic [3:0]  slot_id;
        logic [15:0] layer;
        logic [15:0] texture;
        logic        texture_ok;
        logic        show;
    } t_cmd;

    typedef struct packed {
        logic        status;
        logic [3:0]  slot_out;
        logic [15:0] layer_out;
        logic [15:0] texture_out;
        logic        visible_out;
        logic        has_sprite;
        logic        last;
    } t_res;
endpackage

// ----- hdl/lsdot_if.sv -----
// valid/ready channel interfaces for commands and results
interface lsdot_cmd_if;
    logic                valid;
    logic                ready;
    lsdot_pkg::t_cmd     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lsdot_res_if;
    logic                valid;
    logic                ready;
    lsdot_pkg::t_res     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/layered_sprite_draw_order_table_top.sv -----
// sprite slot table with a layer sorted draw list, one list step per cycle when not stalled
// simple commands offer their item in the cycle after acceptance; create and remove
// walk the list in S_INS or S_REM then S_OUT, a layer change in S_REM, S_INS, S_OUT
// draw all walks the list one entry a cycle unless stalled, one item per visible sprite
// one command at a time; ready returns the cycle after its last item is taken
// synchronous active low reset clears the table, list count and running flag
module layered_sprite_draw_order_table_top #(
    parameter int MAX_SPRITES  = lsdot_pkg::MAX_SPRITES,
    parameter int LAYER_BITS   = lsdot_pkg::LAYER_BITS,
    parameter int TEXTURE_BITS = lsdot_pkg::TEXTURE_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lsdot_cmd_if.sink       i_cmd,
    lsdot_res_if.source     o_res
);
    localparam int SW = $clog2(MAX_SPRITES);
    localparam int CW = $clog2(MAX_SPRITES + 1);
    localparam int QW = lsdot_pkg::SEQ_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_REM  = 3'd1;
    localparam logic [2:0] S_SHD  = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_DRAW = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [MAX_SPRITES-1:0]  r_used, r_vis;
    logic [LAYER_BITS-1:0]   r_layer [MAX_SPRITES];
    logic [QW-1:0]           r_seq   [MAX_SPRITES];
    logic [TEXTURE_BITS-1:0] r_tex   [MAX_SPRITES];
    logic [SW-1:0]           r_list  [MAX_SPRITES];
    logic [CW-1:0]           r_count;
    logic [QW-1:0]           r_nseq;
    logic                    r_run;

    logic [2:0]    r_state;
    logic [CW-1:0] r_idx;
    logic          r_found;
    logic [SW-1:0] r_slot;
    logic          r_ins;
    logic          r_ovalid;
    lsdot_pkg::t_res r_odata;

    // lowest free slot
    logic [SW-1:0] free_slot;
    logic          free_any;
    always_comb begin
        free_slot = '0;
        free_any  = 1'b0;
        for (int k = MAX_SPRITES - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_slot = SW'(k);
                free_any  = 1'b1;
            end
        end
    end

    lsdot_pkg::t_cmd c;
    logic [SW-1:0]         sid;
    logic                  sid_ok;
    logic [LAYER_BITS-1:0] c_lay;
    logic [TEXTURE_BITS-1:0] c_tex;
    assign c      = i_cmd.data;
    assign sid    = SW'(c.slot_id);
    assign sid_ok = r_run && (32'(c.slot_id) < MAX_SPRITES) && r_used[sid];
    assign c_lay  = LAYER_BITS'(signed'(c.layer));
    assign c_tex  = TEXTURE_BITS'(c.texture);

    // shared step unit: one list entry per cycle unless a draw is held by output stall
    logic [SW-1:0] prev_e, cur_e;
    logic          goes_first;
    logic [CW-1:0] idx_m1;
    assign idx_m1 = r_idx - CW'(1);
    assign prev_e = r_list[idx_m1[SW-1:0]];
    assign cur_e  = r_list[r_idx[SW-1:0]];
    always_comb begin
        if (r_layer[prev_e] != r_layer[r_slot])
            goes_first = $signed(r_layer[prev_e]) < $signed(r_layer[r_slot]);
        else
            goes_first = r_seq[prev_e] < r_seq[r_slot];
    end

    assign i_cmd.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_odata;

    function automatic lsdot_pkg::t_res res1(input logic st);
        lsdot_pkg::t_res r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic lsdot_pkg::t_res res_item(input logic [3:0] sl, input logic [15:0] ly,
                                                 input logic [15:0] tx, input logic vis,
                                                 input logic has, input logic lst);
        lsdot_pkg::t_res r;
        r = '0;
        r.slot_out    = sl;
        r.layer_out   = ly;
        r.texture_out = tx;
        r.visible_out = vis;
        r.has_sprite  = has;
        r.last        = lst;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_vis    <= '0;
            r_count  <= '0;
            r_nseq   <= '0;
            r_run    <= 1'b0;
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_ins    <= 1'b0;
            for (int k = 0; k < MAX_SPRITES; k++) begin
                r_layer[k] <= '0;
                r_seq[k]   <= '0;
                r_tex[k]   <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid && i_cmd.ready) begin
                        r_found <= 1'b0;
                        case (c.command)
                            lsdot_pkg::CMD_INIT, lsdot_pkg::CMD_SHUTDOWN,
                            lsdot_pkg::CMD_CLEAR: begin
                                r_ovalid <= 1'b1;
                                if (c.command == lsdot_pkg::CMD_INIT || r_run) begin
                                    r_used  <= '0;
                                    r_vis   <= '0;
                                    r_count <= '0;
                                    r_nseq  <= '0;
                                    for (int k = 0; k < MAX_SPRITES; k++) begin
                                        r_layer[k] <= '0;
                                        r_seq[k]   <= '0;
                                        r_tex[k]   <= '0;
                                    end
                                    r_run <= (c.command != lsdot_pkg::CMD_SHUTDOWN);
                                    r_odata <= res1(1'b0);
                                end else begin
                                    r_odata <= res1(1'b1);
                                end
                            end
                            lsdot_pkg::CMD_CREATE: begin
                                if (c.texture_ok && r_run && free_any) begin
                                    r_used[free_slot]  <= 1'b1;
                                    r_vis[free_slot]   <= 1'b1;
                                    r_tex[free_slot]   <= c_tex;
                                    r_layer[free_slot] <= c_lay;
                                    r_seq[free_slot]   <= r_nseq;
                                    r_nseq  <= r_nseq + QW'(1);
                                    r_slot  <= free_slot;
                                    r_idx   <= r_count;
                                    r_ovalid <= 1'b0;
                                    r_odata <= res_item(4'(free_slot), '0, '0, 1'b0, 1'b0,
                                                        1'b1);
                                    r_state <= S_INS;
                                end else begin
                                    r_ovalid <= 1'b1;
                                    r_odata  <= res1(1'b1);
                                end
                            end
                            lsdot_pkg::CMD_REMOVE: begin
                                if (sid_ok) begin
                                    r_used[sid]  <= 1'b0;
                                    r_vis[sid]   <= 1'b0;
                                    r_layer[sid] <= '0;
                                    r_seq[sid]   <= '0;
                                    r_tex[sid]   <= '0;
                                    r_slot   <= sid;
                                    r_idx    <= '0;
                                    r_ins    <= 1'b0;
                                    r_ovalid <= 1'b0;
                                    r_odata  <= res1(1'b0);
                                    r_state  <= S_REM;
                                end else begin
                                    r_ovalid <= 1'b1;
                                    r_odata  <= res1(1'b1);
                                end
                            end
                            lsdot_pkg::CMD_LAYER: begin
                                if (sid_ok) begin
                                    r_odata <= res1(1'b0);
                                    if (r_layer[sid] != c_lay) begin
                                        r_layer[sid] <= c_lay;
                                        r_slot   <= sid;
                                        r_idx    <= '0;
                                        r_ins    <= 1'b1;
                                        r_ovalid <= 1'b0;
                                        r_state  <= S_REM;
                                    end else begin
                                        r_ovalid <= 1'b1;
                                    end
                                end else begin
                                    r_ovalid <= 1'b1;
                                    r_odata  <= res1(1'b1);
                                end
                            end
                            lsdot_pkg::CMD_VISIBLE: begin
                                r_ovalid <= 1'b1;
                                if (sid_ok) begin
                                    r_vis[sid] <= c.show;
                                    r_odata <= res1(1'b0);
                                end else begin
                                    r_odata <= res1(1'b1);
                                end
                            end
                            lsdot_pkg::CMD_TEXTURE: begin
                                r_ovalid <= 1'b1;
                                if (sid_ok && c.texture_ok) begin
                                    r_tex[sid] <= c_tex;
                                    r_odata <= res1(1'b0);
                                end else begin
                                    r_odata <= res1(1'b1);
                                end
                            end
                            lsdot_pkg::CMD_QUERY: begin
                                r_ovalid <= 1'b1;
                                if (sid_ok) begin
                                    r_odata <= res_item(c.slot_id,
                                                        16'(signed'(r_layer[sid])),
                                                        16'(r_tex[sid]), r_vis[sid],
                                                        1'b0, 1'b1);
                                end else begin
                                    r_odata <= res1(1'b1);
                                end
                            end
                            lsdot_pkg::CMD_DRAW: begin
                                if (r_run) begin
                                    r_idx    <= '0;
                                    r_ovalid <= 1'b0;
                                    r_state  <= S_DRAW;
                                end else begin
                                    r_ovalid <= 1'b1;
                                    r_odata  <= res1(1'b1);
                                end
                            end
                            default: begin
                                r_ovalid <= 1'b1;
                                r_odata  <= res1(1'b1);
                            end
                        endcase
                    end else if (o_res.ready) begin
                        r_ovalid <= 1'b0;
                    end
                end
                S_REM: begin
                    // find the slot then close the gap
                    if (r_idx >= r_count) begin
                        r_idx   <= r_count;
                        r_state <= r_ins ? S_INS : S_OUT;
                    end else if (r_found || cur_e == r_slot) begin
                        r_found <= 1'b1;
                        if (r_idx + CW'(1) < r_count) begin
                            r_list[r_idx[SW-1:0]] <= r_list[SW'(r_idx + CW'(1))];
                            r_idx <= r_idx + CW'(1);
                        end else begin
                            r_count <= r_count - CW'(1);
                            r_idx   <= r_count - CW'(1);
                            r_state <= r_ins ? S_INS : S_OUT;
                        end
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_INS: begin
                    if (r_idx != '0 && !goes_first) begin
                        r_list[r_idx[SW-1:0]] <= prev_e;
                        r_idx <= idx_m1;
                    end else begin
                        r_list[r_idx[SW-1:0]] <= r_slot;
                        r_count <= r_count + CW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_DRAW: begin
                    if (!r_ovalid || o_res.ready) begin
                        if (r_idx >= r_count) begin
                            r_ovalid <= 1'b1;
                            r_odata  <= res1(1'b0);
                            r_state  <= S_SHD;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                            if (r_used[cur_e] && r_vis[cur_e]) begin
                                r_ovalid <= 1'b1;
                                r_odata  <= res_item(4'(cur_e),
                                                     16'(signed'(r_layer[cur_e])),
                                                     16'(r_tex[cur_e]), 1'b1, 1'b1, 1'b0);
                            end else begin
                                r_ovalid <= 1'b0;
                            end
                        end
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_odata.last <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_SHD: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hdl/lsdot_checker.sv -----
// port level checks on the draw order table
module lsdot_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            cmd_valid,
    input logic            cmd_ready,
    input logic            res_valid,
    input logic            res_ready,
    input lsdot_pkg::t_res res_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("ready during command");
    a_noready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !cmd_ready)
        else $error("command taken while result pending");
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res_data.has_sprite |-> !res_data.last)
        else $error("sprite item flagged last");
endmodule

bind layered_sprite_draw_order_table_top lsdot_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .cmd_valid(i_cmd.valid), .cmd_ready(i_cmd.ready),
    .res_valid(o_res.valid), .res_ready(o_res.ready), .res_data(o_res.data)
);
